/* design/quaternion_delta_angular_rate_top_assert.svh */
// assertion macros used by the port-level checker
`ifndef QUATERNION_DELTA_ANGULAR_RATE_TOP_ASSERT_SVH
`define QUATERNION_DELTA_ANGULAR_RATE_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define QDAR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define QDAR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/qdar_pkg.sv */
// shared types, constants and tables of the quaternion delta rate block
`timescale 1ns / 1ps

package qdar_pkg;

    localparam int QW         = 16;  // quaternion component width
    localparam int OW         = 15;  // output field width
    localparam int WIDE_W     = 52;  // working quaternion accumulator
    localparam int SRC_W      = 32;  // shrunk operand quaternion
    localparam int MUL_W      = 33;  // shared multiplier operand
    localparam int PROD_W     = 64;  // kept product bits
    localparam int CORDIC_W   = 34;
    localparam int Z_W        = 33;
    localparam int ROOT_W     = 64;
    localparam int DEN_W      = 49;
    localparam int QUOT_W     = 16;
    localparam int CNT_W      = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int OUT_FRAC   = 12;
    localparam int ANG_SHIFT  = 30 - OUT_FRAC;
    localparam int SMALL_SH   = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int SHRINK_BIT = 30;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXT_EN = 3'd0,
        CFG_EXT_W  = 3'd1,
        CFG_EXT_X  = 3'd2,
        CFG_EXT_Y  = 3'd3,
        CFG_EXT_Z  = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_MAX,
        ST_SHIFT,
        ST_NEG,
        ST_SQ,
        ST_SQRT,
        ST_BRANCH,
        ST_CORDIC,
        ST_PROD,
        ST_DIVGO,
        ST_DIVWAIT,
        ST_DONE
    } state_t;

    // which quaternion product is running
    typedef enum logic [1:0] {
        PASS_REL,
        PASS_EC,
        PASS_TE,
        PASS_FIN
    } pass_t;

    typedef struct packed {
        logic                start;
        logic [PROD_W-1:0]   num;
        logic [DEN_W-1:0]    den;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [QUOT_W-1:0]   quot;
    } div_rsp_t;

    // atan(2^-i) in Q30 radians
    function automatic logic [29:0] atan_q30(input logic [CNT_W-1:0] i);
        logic [29:0] v;
        unique case (i)
            5'd0:  v = 30'h3243F6A8;
            5'd1:  v = 30'h1DAC6705;
            5'd2:  v = 30'h0FADBAFC;
            5'd3:  v = 30'h07F56EA6;
            5'd4:  v = 30'h03FEAB76;
            5'd5:  v = 30'h01FFD55B;
            5'd6:  v = 30'h00FFFAAA;
            5'd7:  v = 30'h007FFF55;
            5'd8:  v = 30'h003FFFEA;
            5'd9:  v = 30'h001FFFFD;
            5'd10: v = 30'h000FFFFF;
            5'd11: v = 30'h0007FFFF;
            5'd12: v = 30'h0003FFFF;
            5'd13: v = 30'h0001FFFF;
            5'd14: v = 30'h0000FFFF;
            5'd15: v = 30'h00007FFF;
            5'd16: v = 30'h00003FFF;
            5'd17: v = 30'h00001FFF;
            5'd18: v = 30'h00000FFF;
            5'd19: v = 30'h000007FF;
            5'd20: v = 30'h000003FF;
            5'd21: v = 30'h000001FF;
            5'd22: v = 30'h000000FF;
            5'd23: v = 30'h0000007F;
            5'd24: v = 30'h0000003F;
            5'd25: v = 30'h0000001F;
            5'd26: v = 30'h0000000F;
            5'd27: v = 30'h00000008;
            5'd28: v = 30'h00000004;
            5'd29: v = 30'h00000002;
            5'd30: v = 30'h00000001;
            default: v = 30'h00000000;
        endcase
        return v;
    endfunction

    // minus signs of the hamilton product, output k, term j
    function automatic logic term_neg(input logic [1:0] k, input logic [1:0] j);
        logic n;
        unique case ({k, j})
            4'b0001, 4'b0010, 4'b0011, 4'b0111, 4'b1001, 4'b1110: n = 1'b1;
            default: n = 1'b0;
        endcase
        return n;
    endfunction

    // signed result from magnitude, saturated to the output range
    function automatic logic signed [OW-1:0] sat_rate(input logic neg,
                                                     input logic [QUOT_W-1:0] q);
        logic signed [QUOT_W:0] v;
        logic signed [OW-1:0]   r;
        v = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        if (v > 17'sd16383)
            r = 15'sd16383;
        else if (v < -17'sd16384)
            r = -15'sd16384;
        else
            r = v[OW-1:0];
        return r;
    endfunction

endpackage

/* design/qdar_div.sv */
// restoring divider with a 16-bit quotient, one bit per cycle
`timescale 1ns / 1ps

module qdar_div
    import qdar_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                busy_reg;
    logic                done_reg;
    logic [3:0]          cnt_reg;
    logic [PROD_W-1:0]   rem_reg;
    logic [PROD_W-1:0]   dsh_reg;
    logic [QUOT_W-1:0]   quot_reg;
    logic                ge;

    // trial subtract of the shifted divisor
    assign ge = (rem_reg >= dsh_reg);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 4'(QUOT_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 4'd1;
                end
            end
        end
    end

    // remainder and quotient
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= req.num;
            dsh_reg  <= {req.den, {(QUOT_W - 1){1'b0}}};
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (ge)
                rem_reg <= rem_reg - dsh_reg;
            quot_reg <= {quot_reg[QUOT_W-2:0], ge};
            dsh_reg  <= dsh_reg >> 1;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

/* design/quaternion_delta_angular_rate_top.sv */
// Quaternion delta angular rate: SO(3) log of the relative rotation of two samples
//
// Input channel (sample_valid / sample_stall) takes one orientation quaternion
// in Q1.14 with a restart flag. Output channel (rate_valid / rate_stall) gives
// one result per sample: valid_res, the rotation vector rate_x/y/z and
// rotation_angle, all Q2.12 radians. Each sample becomes the stored previous
// sample; the first sample after reset or a restart gives valid_res = 0.
// One shared 33x33 multiplier, a shift/compare step, a 16-step CORDIC and a
// bit-serial divider work under a sequencer, one sample at a time; sample_stall
// is high from accept until the result is in the output register.
// A sample with no rate goes straight to the output register; a rate takes
// longer, and more when the extrinsic rotation is enabled, most of it in the
// quaternion products, the 32-step square root and the three 16-step divisions.
// Reset clears the previous sample, loads the identity extrinsic and empties
// the output register. A stalled result holds in the output register; the
// block may accept and work on the next sample meanwhile, and waits at its
// end until the output register is free.
// Configuration is written through cfg_write_en / cfg_index / cfg_data; the
// user must write it only while idle, as the block does not enforce this.
`timescale 1ns / 1ps

module quaternion_delta_angular_rate_top
    import qdar_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        sample_valid,
    output logic                        sample_stall,
    input  logic                        restart,
    input  logic signed [QW-1:0]        quat_w,
    input  logic signed [QW-1:0]        quat_x,
    input  logic signed [QW-1:0]        quat_y,
    input  logic signed [QW-1:0]        quat_z,
    output logic                        rate_valid,
    input  logic                        rate_stall,
    output logic                        valid_res,
    output logic signed [OW-1:0]        rate_x,
    output logic signed [OW-1:0]        rate_y,
    output logic signed [OW-1:0]        rate_z,
    output logic signed [OW-1:0]        rotation_angle,
    input  logic                        cfg_write_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [QW-1:0]               cfg_data
);

    state_t                  state_reg, state_next;
    pass_t                   pass_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    ph_reg;

    logic                    ext_en_reg;
    logic signed [QW-1:0]    ext_reg [4];
    logic signed [QW-1:0]    prev_reg [4];
    logic signed [QW-1:0]    old_reg [4];
    logic                    have_prev_reg;

    logic signed [WIDE_W-1:0] q_reg [4];
    logic signed [WIDE_W-1:0] acc_reg;
    logic signed [SRC_W-1:0]  src_reg [4];
    logic [WIDE_W-1:0]        m_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [ROOT_W-1:0]        sq_reg;
    logic [ROOT_W-1:0]        root_reg;
    logic signed [CORDIC_W-1:0] x_reg, y_reg;
    logic signed [Z_W-1:0]    z_reg;

    logic signed [OW-1:0]     res_reg [3];
    logic signed [OW-1:0]     ang_reg;
    logic                     vres_reg;

    logic                     rate_valid_reg;
    logic                     valid_res_reg;
    logic signed [OW-1:0]     rate_x_reg, rate_y_reg, rate_z_reg, angle_reg;

    div_req_t                 div_req;
    div_rsp_t                 div_rsp;

    logic                     accept;
    logic                     out_free;
    logic                     out_load;
    logic                     cnt_keep;
    logic [1:0]               j, k, kj, src_idx, ext_idx;
    logic signed [SRC_W-1:0]  src_rd;
    logic signed [QW-1:0]     ext_rd;
    logic signed [MUL_W-1:0]  src_abs;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [2*MUL_W-1:0] mul_full;
    logic signed [WIDE_W-1:0] term, acc_sum;
    logic                     tneg;
    logic signed [WIDE_W-1:0] q_rd;
    logic [WIDE_W-1:0]        q_mag;
    logic                     shrink_go;
    logic [ROOT_W-1:0]        bitv, rb, root_next;
    logic                     sq_ge;
    logic [30:0]              n_val;
    logic                     near_zero;
    logic [4:0]               sh;
    logic signed [CORDIC_W-1:0] xs, ys;
    logic                     y_pos;
    logic [31:0]              th;
    logic [32:0]              ang_sum;

    // handshake
    assign accept   = (state_reg == ST_IDLE) && sample_valid;
    assign out_free = !rate_valid_reg || !rate_stall;
    assign out_load = (state_reg == ST_DONE) && out_free;

    // operand indexes
    assign j  = cnt_reg[1:0];
    assign k  = cnt_reg[3:2];
    assign kj = k ^ j;

    always_comb
    begin
        priority if (state_reg == ST_MUL && pass_reg == PASS_TE)
            src_idx = j;
        else if (state_reg == ST_MUL)
            src_idx = kj;
        else
            src_idx = cnt_reg[1:0] + 2'd1;
    end

    assign ext_idx = (pass_reg == PASS_TE) ? kj : j;
    assign src_rd  = src_reg[src_idx];
    assign ext_rd  = ext_reg[ext_idx];
    assign src_abs = src_rd[SRC_W-1] ? -MUL_W'(src_rd) : MUL_W'(src_rd);

    // half angle doubled, clamped at zero
    assign th = z_reg[Z_W-1] ? 32'd0 : {z_reg[30:0], 1'b0};

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MUL:
            begin
                unique case (pass_reg)
                    PASS_REL:
                    begin
                        mul_a = MUL_W'(old_reg[j]);
                        mul_b = MUL_W'(prev_reg[kj]);
                    end
                    PASS_EC:
                    begin
                        mul_a = MUL_W'(ext_rd);
                        mul_b = MUL_W'(src_rd);
                    end
                    PASS_TE, PASS_FIN:
                    begin
                        mul_a = MUL_W'(src_rd);
                        mul_b = MUL_W'(ext_rd);
                    end
                endcase
            end
            ST_SQ:
            begin
                mul_a = MUL_W'(src_rd);
                mul_b = MUL_W'(src_rd);
            end
            ST_PROD:
            begin
                mul_a = $signed({1'b0, th});
                mul_b = src_abs;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    // product term accumulate with hamilton signs, conjugate on the left in PASS_REL and PASS_EC
    assign term    = prod_reg[WIDE_W-1:0];
    assign tneg    = term_neg(k, j) ^
                     ((pass_reg == PASS_REL || pass_reg == PASS_EC) && (j != 2'd0));
    assign acc_sum = ((j == 2'd0) ? WIDE_W'(0) : acc_reg) + (tneg ? -term : term);

    // shrink: largest magnitude and shift test
    assign q_rd      = q_reg[cnt_reg[1:0]];
    assign q_mag     = q_rd[WIDE_W-1] ? WIDE_W'(-q_rd) : WIDE_W'(q_rd);
    assign shrink_go = |m_reg[WIDE_W-1:SHRINK_BIT];

    // square root step
    assign bitv      = ROOT_W'(1) << (6'd62 - {cnt_reg, 1'b0});
    assign rb        = root_reg + bitv;
    assign sq_ge     = (sq_reg >= rb);
    assign root_next = sq_ge ? ((root_reg >> 1) + bitv) : (root_reg >> 1);

    // small-angle test: below output resolution gives zero
    assign n_val     = root_reg[30:0];
    assign near_zero = (n_val == '0) ||
                       ({1'b0, n_val} < {16'd0, src_reg[0][SRC_W-1:SMALL_SH]});

    // cordic vectoring step
    assign sh    = cnt_reg;
    assign xs    = x_reg >>> sh;
    assign ys    = y_reg >>> sh;
    assign y_pos = !y_reg[CORDIC_W-1] && (y_reg != '0);

    assign ang_sum = {1'b0, th} + 33'(1 << (ANG_SHIFT - 1));

    // divider request
    assign div_req.num = prod_reg + PROD_W'({n_val, {(ANG_SHIFT - 1){1'b0}}});
    assign div_req.den = {n_val, {ANG_SHIFT{1'b0}}};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (sample_valid)
                    state_next = (have_prev_reg && !restart) ? ST_MUL : ST_DONE;
            ST_MUL:
                if (ph_reg && cnt_reg == 5'd15)
                    state_next = ((pass_reg == PASS_REL && !ext_en_reg) ||
                                  pass_reg == PASS_TE) ? ST_NEG : ST_MAX;
            ST_MAX:
                if (cnt_reg[1:0] == 2'd3)
                    state_next = ST_SHIFT;
            ST_SHIFT:
                if (!shrink_go)
                    state_next = (pass_reg == PASS_FIN) ? ST_SQ : ST_MUL;
            ST_NEG:
                state_next = ST_MAX;
            ST_SQ:
                if (ph_reg && cnt_reg == 5'd2)
                    state_next = ST_SQRT;
            ST_SQRT:
                if (cnt_reg == 5'd31)
                    state_next = ST_BRANCH;
            ST_BRANCH:
                state_next = near_zero ? ST_DONE : ST_CORDIC;
            ST_CORDIC:
                if (cnt_reg == 5'(CORDIC_STEPS - 1))
                    state_next = ST_PROD;
            ST_PROD:
                state_next = ST_DIVGO;
            ST_DIVGO:
                state_next = ST_DIVWAIT;
            ST_DIVWAIT:
                if (div_rsp.done)
                    state_next = (cnt_reg == 5'd2) ? ST_DONE : ST_PROD;
            ST_DONE:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // state machine outputs
    always_comb
    begin
        sample_stall  = (state_reg != ST_IDLE);
        div_req.start = (state_reg == ST_DIVGO);
        cnt_keep      = (state_reg == ST_PROD) || (state_reg == ST_DIVGO) ||
                        (state_reg == ST_DIVWAIT);
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pass_reg  <= PASS_REL;
            cnt_reg   <= '0;
            ph_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
                pass_reg <= PASS_REL;
            else if (state_reg == ST_MUL && state_next == ST_NEG)
                pass_reg <= PASS_FIN;
            else if (state_reg == ST_SHIFT && state_next == ST_MUL)
                pass_reg <= pass_t'(pass_reg + 2'd1);

            if (state_next != state_reg && !cnt_keep)
            begin
                cnt_reg <= '0;
                ph_reg  <= 1'b0;
            end
            else
            begin
                unique case (state_reg)
                    ST_MUL, ST_SQ:
                    begin
                        ph_reg <= !ph_reg;
                        if (ph_reg)
                            cnt_reg <= cnt_reg + 5'd1;
                    end
                    ST_MAX, ST_SQRT, ST_CORDIC:
                        cnt_reg <= cnt_reg + 5'd1;
                    ST_DIVWAIT:
                        if (div_rsp.done)
                            cnt_reg <= cnt_reg + 5'd1;
                    default:
                        cnt_reg <= cnt_reg;
                endcase
            end
        end
    end

    // configuration, stored sample and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_en_reg     <= 1'b0;
            ext_reg[0]     <= QW'(1 << 14);
            ext_reg[1]     <= '0;
            ext_reg[2]     <= '0;
            ext_reg[3]     <= '0;
            prev_reg[0]    <= '0;
            prev_reg[1]    <= '0;
            prev_reg[2]    <= '0;
            prev_reg[3]    <= '0;
            have_prev_reg  <= 1'b0;
            rate_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    CFG_EXT_EN: ext_en_reg <= cfg_data[0];
                    CFG_EXT_W:  ext_reg[0] <= cfg_data;
                    CFG_EXT_X:  ext_reg[1] <= cfg_data;
                    CFG_EXT_Y:  ext_reg[2] <= cfg_data;
                    CFG_EXT_Z:  ext_reg[3] <= cfg_data;
                    default:    ext_en_reg <= ext_en_reg;
                endcase
            end
            if (accept)
            begin
                prev_reg[0]   <= quat_w;
                prev_reg[1]   <= quat_x;
                prev_reg[2]   <= quat_y;
                prev_reg[3]   <= quat_z;
                have_prev_reg <= 1'b1;
            end
            if (out_load)
                rate_valid_reg <= 1'b1;
            else if (!rate_stall)
                rate_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        // sample capture
        if (accept)
        begin
            for (int i = 0; i < 4; i++)
                old_reg[i] <= prev_reg[i];
            if (!(have_prev_reg && !restart))
            begin
                for (int i = 0; i < 3; i++)
                    res_reg[i] <= '0;
                ang_reg  <= '0;
                vres_reg <= 1'b0;
            end
        end

        // shared multiplier
        if ((state_reg == ST_MUL || state_reg == ST_SQ) && !ph_reg)
            prod_reg <= mul_full[PROD_W-1:0];
        if (state_reg == ST_PROD)
            prod_reg <= mul_full[PROD_W-1:0];

        // quaternion product accumulate
        if (state_reg == ST_MUL && ph_reg)
        begin
            acc_reg <= acc_sum;
            if (j == 2'd3)
                q_reg[k] <= acc_sum;
        end

        // flip sign so that w is not negative
        if (state_reg == ST_NEG && q_reg[0][WIDE_W-1])
        begin
            for (int i = 0; i < 4; i++)
                q_reg[i] <= -q_reg[i];
        end

        // largest magnitude scan
        if (state_next == ST_MAX && state_reg != ST_MAX)
            m_reg <= '0;
        else if (state_reg == ST_MAX && q_mag > m_reg)
            m_reg <= q_mag;

        // common right shift until below 2^30
        if (state_reg == ST_SHIFT)
        begin
            if (shrink_go)
            begin
                m_reg <= m_reg >> 1;
                for (int i = 0; i < 4; i++)
                    q_reg[i] <= q_reg[i] >>> 1;
            end
            else
            begin
                for (int i = 0; i < 4; i++)
                    src_reg[i] <= q_reg[i][SRC_W-1:0];
            end
        end

        // squared norm of the vector part
        if (state_next == ST_SQ && state_reg != ST_SQ)
            sq_reg <= '0;
        else if (state_reg == ST_SQ && ph_reg)
            sq_reg <= sq_reg + prod_reg;

        // integer square root
        if (state_next == ST_SQRT && state_reg != ST_SQRT)
            root_reg <= '0;
        else if (state_reg == ST_SQRT)
        begin
            root_reg <= root_next;
            if (sq_ge)
                sq_reg <= sq_reg - rb;
        end

        // branch: zero result or cordic start
        if (state_reg == ST_BRANCH)
        begin
            if (near_zero)
            begin
                for (int i = 0; i < 3; i++)
                    res_reg[i] <= '0;
                ang_reg  <= '0;
                vres_reg <= 1'b1;
            end
            else
            begin
                x_reg <= CORDIC_W'(src_reg[0]);
                y_reg <= CORDIC_W'({1'b0, n_val});
                z_reg <= '0;
            end
        end

        // cordic vectoring
        if (state_reg == ST_CORDIC)
        begin
            if (y_pos)
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + Z_W'(atan_q30(cnt_reg));
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - Z_W'(atan_q30(cnt_reg));
            end
        end

        // quotient to signed rate, angle with the last one
        if (state_reg == ST_DIVWAIT && div_rsp.done)
        begin
            res_reg[cnt_reg[1:0]] <= sat_rate(src_rd[SRC_W-1], div_rsp.quot);
            if (cnt_reg == 5'd2)
            begin
                ang_reg  <= sat_rate(1'b0, {1'b0, ang_sum[32:ANG_SHIFT]});
                vres_reg <= 1'b1;
            end
        end

        // output register
        if (out_load)
        begin
            valid_res_reg <= vres_reg;
            rate_x_reg    <= res_reg[0];
            rate_y_reg    <= res_reg[1];
            rate_z_reg    <= res_reg[2];
            angle_reg     <= ang_reg;
        end
    end

    qdar_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign rate_valid     = rate_valid_reg;
    assign valid_res      = valid_res_reg;
    assign rate_x         = rate_x_reg;
    assign rate_y         = rate_y_reg;
    assign rate_z         = rate_z_reg;
    assign rotation_angle = angle_reg;

endmodule

/* design/qdar_chk.sv */
// port-level checker for the quaternion delta rate block, with its bind
`timescale 1ns / 1ps

`include "quaternion_delta_angular_rate_top_assert.svh"

module qdar_chk
(
    input logic               clk,
    input logic               rst_n,
    input logic               sample_valid,
    input logic               sample_stall,
    input logic               restart,
    input logic signed [15:0] quat_w,
    input logic signed [15:0] quat_x,
    input logic signed [15:0] quat_y,
    input logic signed [15:0] quat_z,
    input logic               rate_valid,
    input logic               rate_stall,
    input logic               valid_res,
    input logic signed [14:0] rate_x,
    input logic signed [14:0] rate_y,
    input logic signed [14:0] rate_z,
    input logic signed [14:0] rotation_angle,
    input logic               cfg_write_en,
    input logic [2:0]         cfg_index,
    input logic [15:0]        cfg_data
);

    // a stalled result stays valid and keeps its rate vector
    `QDAR_ASSERT_NXT(a_stall_hold, rate_valid && rate_stall, rate_valid && $stable(rate_x) && $stable(rate_y) && $stable(rate_z), "stalled result changed")

    // no previous sample means an all-zero result
    `QDAR_ASSERT_NOW(a_norate_zero, rate_valid && !valid_res, rate_x == 15'sd0 && rate_y == 15'sd0 && rate_z == 15'sd0 && rotation_angle == 15'sd0, "result without rate is not zero")

    // the angle is never negative
    `QDAR_ASSERT_NOW(a_angle_pos, rate_valid, !rotation_angle[14], "negative rotation angle")

    // a zero angle carries a zero rotation vector
    `QDAR_ASSERT_NOW(a_zero_angle, rate_valid && rotation_angle == 15'sd0, rate_x == 15'sd0 && rate_y == 15'sd0 && rate_z == 15'sd0, "rate with zero angle")

endmodule

bind quaternion_delta_angular_rate_top qdar_chk u_qdar_chk (.*);
